// File: hdl/lfp_pkg.sv
// ----------------------------------------------------------------------------
// lfp_pkg - shared types and constants of the LOAS/LATM frame packer
// Request payload structs, queue entry layout and register indexes.
// ----------------------------------------------------------------------------
package lfp_pkg;

    // Largest access unit accepted; longer units are saturated to this
    localparam logic [9:0] LFP_MAX_AU_BYTES = 10'd960;

    // Front/back queue
    localparam int LFP_QDEPTH = 4;
    localparam int LFP_QAW    = $clog2(LFP_QDEPTH);
    localparam int LFP_QCW    = $clog2(LFP_QDEPTH + 1);

    // Input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_SBR_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_DAC_RATE_48K = 2'd1;
    localparam logic [1:0] CFG_STEREO_MODE = 2'd2;

    // Header constants
    localparam logic [10:0] LFP_SYNCWORD   = 11'h2B7;
    localparam logic [4:0]  LFP_AOT_SBR    = 5'b00101;
    localparam logic [4:0]  LFP_AOT_LC     = 5'b00010;
    localparam logic [2:0]  LFP_GA_CONFIG  = 3'b100;
    localparam logic [7:0]  LFP_FULLNESS   = 8'hFF;

    typedef struct packed {
        logic       action;
        logic [9:0] au_length;
        logic [7:0] payload_byte;
    } t_lfp_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } t_lfp_out;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_LAST  = 2'd2
    } t_lfp_kind;

    // One classified request for the back end
    typedef struct packed {
        t_lfp_kind   kind;
        logic [7:0]  data_byte;
        logic        sbr;
        logic [3:0]  core;
        logic [3:0]  chan;
        logic [3:0]  ext;
        logic [2:0]  nlen;
        logic [7:0]  rem;
        logic [12:0] total_m3;
        logic [3:0]  hcnt;
        logic        empty;
    } t_lfp_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_lfp_qstat;

endpackage

// File: hdl/lfp_front.sv
// ----------------------------------------------------------------------------
// lfp_front - request intake and classification
// Holds the configuration registers and the open-frame byte count, drops
// stray payload bytes and precomputes header fields for each start request.
// ----------------------------------------------------------------------------
module lfp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lfp_pkg::t_lfp_in    i_in_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic                i_cfg_data,
    input  lfp_pkg::t_lfp_qstat i_qstat,
    output logic                o_push,
    output lfp_pkg::t_lfp_entry o_entry
);
    import lfp_pkg::*;

    logic       r_sbr, r_dac48, r_stereo;
    logic [9:0] r_bytes_left, n_bytes_left;
    logic       accept;
    logic [9:0] len_sat;
    logic [9:0] sub;
    logic [2:0] nlen;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_qstat.full;
    assign accept      = i_in_valid && !i_qstat.full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbr    <= 1'b0;
            r_dac48  <= 1'b1;
            r_stereo <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SBR_ENABLE:   r_sbr    <= i_cfg_data;
                CFG_DAC_RATE_48K: r_dac48  <= i_cfg_data;
                CFG_STEREO_MODE:  r_stereo <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // length saturation and 255-coding
    always_comb begin
        len_sat = (i_in_data.au_length > LFP_MAX_AU_BYTES) ? LFP_MAX_AU_BYTES
                                                           : i_in_data.au_length;
        if (len_sat >= 10'd765) begin
            nlen = 3'd4;
            sub  = 10'd765;
        end else if (len_sat >= 10'd510) begin
            nlen = 3'd3;
            sub  = 10'd510;
        end else if (len_sat >= 10'd255) begin
            nlen = 3'd2;
            sub  = 10'd255;
        end else begin
            nlen = 3'd1;
            sub  = 10'd0;
        end
    end

    // classify the request and build the queue entry
    always_comb begin
        logic [9:0] diff;
        diff             = len_sat - sub;
        o_entry          = '0;
        o_entry.data_byte = i_in_data.payload_byte;
        o_entry.sbr      = r_sbr;
        o_entry.core     = r_dac48 ? (r_sbr ? 4'd6 : 4'd3) : (r_sbr ? 4'd8 : 4'd5);
        o_entry.ext      = r_dac48 ? 4'd3 : 4'd5;
        o_entry.chan     = r_stereo ? 4'd2 : 4'd1;
        o_entry.nlen     = nlen;
        o_entry.rem      = diff[7:0];
        o_entry.total_m3 = 13'(len_sat) + 13'(nlen) + (r_sbr ? 13'd7 : 13'd6);
        o_entry.empty    = (len_sat == 10'd0);
        o_entry.hcnt     = 4'(nlen) + (r_sbr ? 4'd9 : 4'd8) + 4'(o_entry.empty);
        n_bytes_left     = r_bytes_left;
        o_push           = 1'b0;
        if (i_in_data.action == ACT_START) begin
            o_entry.kind = KIND_START;
        end else if (r_bytes_left == 10'd1) begin
            o_entry.kind = KIND_LAST;
        end else begin
            o_entry.kind = KIND_DATA;
        end
        if (accept) begin
            if (i_in_data.action == ACT_START) begin
                o_push       = 1'b1;
                n_bytes_left = len_sat;
            end else if (r_bytes_left != 10'd0) begin
                o_push       = 1'b1;
                n_bytes_left = r_bytes_left - 10'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
        end else begin
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule

// File: hdl/lfp_queue.sv
// ----------------------------------------------------------------------------
// lfp_queue - short register queue between front and back
// Simultaneous push and pop supported; head entry read directly.
// ----------------------------------------------------------------------------
module lfp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lfp_pkg::t_lfp_entry i_entry,
    input  logic                i_pop,
    output lfp_pkg::t_lfp_entry o_head,
    output lfp_pkg::t_lfp_qstat o_qstat
);
    import lfp_pkg::*;

    t_lfp_entry           r_mem [LFP_QDEPTH];
    logic [LFP_QAW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [LFP_QCW-1:0]   r_count;

    assign o_head        = r_mem[r_rd_ptr];
    assign o_qstat.full  = (r_count == LFP_QCW'(LFP_QDEPTH));
    assign o_qstat.empty = (r_count == '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LFP_QAW'(LFP_QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LFP_QAW'(LFP_QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hdl/lfp_back.sv
// ----------------------------------------------------------------------------
// lfp_back - bit packer and output register
// Shifts header bytes out, realigns payload bytes by the header's leftover
// bit count and appends the zero-padded final byte.
// ----------------------------------------------------------------------------
module lfp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lfp_pkg::t_lfp_entry i_head,
    input  lfp_pkg::t_lfp_qstat i_qstat,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lfp_pkg::t_lfp_out   o_out_data
);
    import lfp_pkg::*;

    logic [127:0] r_hdr, n_hdr;
    logic [3:0]   r_hcnt, n_hcnt;
    logic         r_hend, n_hend;
    logic         r_pad, n_pad;
    logic [6:0]   r_res, n_res;
    logic [2:0]   r_rcnt, n_rcnt;
    logic         r_ovalid, n_ovalid;
    t_lfp_out     r_out, n_out;

    logic         out_free;
    logic [127:0] hdr_build;
    logic [31:0]  tail;
    logic [14:0]  word_sh;
    logic [7:0]   hnext;
    logic [7:0]   pad_byte;
    logic [6:0]   mask;

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign out_free    = !r_ovalid || !i_out_stall;

    // header image for the entry at the head of the queue, left aligned
    always_comb begin
        case (i_head.nlen)
            3'd1:    tail = {i_head.rem, 24'h0};
            3'd2:    tail = {8'hFF, i_head.rem, 16'h0};
            3'd3:    tail = {16'hFFFF, i_head.rem, 8'h0};
            default: tail = {24'hFFFFFF, i_head.rem};
        endcase
        if (i_head.sbr) begin
            hdr_build = {LFP_SYNCWORD, i_head.total_m3, 3'b001, 13'b0,
                         LFP_AOT_SBR, i_head.core, i_head.chan, i_head.ext,
                         LFP_AOT_LC, LFP_GA_CONFIG,
                         3'b000, LFP_FULLNESS, 2'b00, tail, 18'b0};
        end else begin
            hdr_build = {LFP_SYNCWORD, i_head.total_m3, 3'b001, 13'b0,
                         LFP_AOT_LC, i_head.core, i_head.chan, LFP_GA_CONFIG,
                         3'b000, LFP_FULLNESS, 2'b00, tail, 27'b0};
        end
    end

    // realignment helpers
    assign word_sh  = {r_res, i_head.data_byte} >> r_rcnt;
    assign hnext    = r_hdr[119:112] >> (4'd8 - {1'b0, r_rcnt});
    assign pad_byte = 8'({1'b0, r_res} << (4'd8 - {1'b0, r_rcnt}));
    assign mask     = ~(7'h7F << r_rcnt);

    // emit selection: header bytes, then pending pad, then next request
    always_comb begin
        n_hdr    = r_hdr;
        n_hcnt   = r_hcnt;
        n_hend   = r_hend;
        n_pad    = r_pad;
        n_res    = r_res;
        n_rcnt   = r_rcnt;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        o_pop    = 1'b0;
        if (out_free) begin
            n_ovalid = 1'b0;
            if (r_hcnt != 4'd0) begin
                n_ovalid          = 1'b1;
                n_out.out_byte    = r_hdr[127:120];
                n_out.frame_end   = (r_hcnt == 4'd1) && r_hend;
                n_hdr             = r_hdr << 8;
                n_hcnt            = r_hcnt - 4'd1;
                if (r_hcnt == 4'd1) begin
                    if (r_hend) begin
                        n_res  = '0;
                        n_rcnt = '0;
                    end else begin
                        n_res  = hnext[6:0];
                    end
                end
            end else if (r_pad) begin
                n_ovalid        = 1'b1;
                n_out.out_byte  = pad_byte;
                n_out.frame_end = 1'b1;
                n_pad           = 1'b0;
                n_res           = '0;
                n_rcnt          = '0;
            end else if (!i_qstat.empty) begin
                o_pop = 1'b1;
                case (i_head.kind)
                    KIND_START: begin
                        n_hdr  = hdr_build;
                        n_hcnt = i_head.hcnt;
                        n_hend = i_head.empty;
                        n_rcnt = i_head.sbr ? 3'd6 : 3'd5;
                        n_res  = '0;
                    end
                    KIND_DATA, KIND_LAST: begin
                        n_ovalid        = 1'b1;
                        n_out.out_byte  = word_sh[7:0];
                        n_out.frame_end = 1'b0;
                        n_res           = i_head.data_byte[6:0] & mask;
                        if (i_head.kind == KIND_LAST) begin
                            if (r_rcnt != 3'd0) begin
                                n_pad = 1'b1;
                            end else begin
                                n_out.frame_end = 1'b1;
                                n_res           = '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt   <= '0;
            r_hend   <= 1'b0;
            r_pad    <= 1'b0;
            r_res    <= '0;
            r_rcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_hcnt   <= n_hcnt;
            r_hend   <= n_hend;
            r_pad    <= n_pad;
            r_res    <= n_res;
            r_rcnt   <= n_rcnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
        r_out <= n_out;
    end

endmodule

// File: hdl/latm_loas_frame_packer.sv
// ----------------------------------------------------------------------------
// latm_loas_frame_packer - LOAS AudioSyncStream / LATM AudioMuxElement packer
// Front end classifies requests, a 4-entry queue decouples it from the bit
// packer, which drives a registered output.
// ----------------------------------------------------------------------------
// Payload byte: queue register, then output register; one byte per cycle while
//   the output is not stalled. Start request: loads the header shifter, then
//   one header byte per cycle likewise (9 to 13 bytes); residue is zero-padded.
// Input stalls only when the 4-entry front/back queue is full.
// Synchronous active-low reset clears queue, residue and counts, and returns
//   the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module latm_loas_frame_packer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lfp_pkg::t_lfp_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lfp_pkg::t_lfp_out o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic              i_cfg_data
);
    import lfp_pkg::*;

    logic       q_push, q_pop;
    t_lfp_entry q_entry, q_head;
    t_lfp_qstat q_stat;

    // request intake
    lfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_qstat     (q_stat),
        .o_push      (q_push),
        .o_entry     (q_entry)
    );

    // decoupling queue
    lfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_entry),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_qstat (q_stat)
    );

    // bit packer
    lfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_qstat     (q_stat),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    // a stalled result keeps the queue head waiting
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !q_pop)
        else $error("queue popped while output stalled");
`endif

endmodule
